FILE: src/lptc_pkg.sv
// Shared types and constants for the LRU page translation cache.
// Used by lptc_ctrl, lptc_dp and lru_page_translation_cache_unit; no dependencies.
package lptc_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int KIND_W      = 2;
	localparam int PID_W       = 8;
	localparam int PAGE_W      = 16;
	localparam int FRAME_W     = 16;
	localparam int QUOTA_W     = 5;

	localparam logic [QUOTA_W-1:0] QUOTA_RST = QUOTA_W'(4);
	localparam logic [QUOTA_W-1:0] QUOTA_MIN = QUOTA_W'(1);

	typedef enum logic [KIND_W-1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_REMOVE = 2'd2
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic capture;
		logic apply;
	} cmd_t;

endpackage

FILE: src/lptc_ctrl.sv
// Controller state machine for the LRU page translation cache.
// Depends on lptc_pkg; drives the capture and apply commands of lptc_dp.
module lptc_ctrl
	import lptc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx    = state_q;
		in_stall    = 1'b1;
		cmd.capture = 1'b0;
		cmd.apply   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_nx = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = out_free;
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.apply) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_apply_only_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> $past(cmd.capture) || $past(state_q == ST_APPLY))
		else $error("apply without a captured transaction");

	a_apply_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> out_valid)
		else $error("result not presented after apply");

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> in_stall)
		else $error("input accepted while a transaction is in flight");

endmodule

FILE: src/lptc_dp.sv
// Datapath for the LRU page translation cache: slot stack, match vectors, result register.
// Depends on lptc_pkg; sequenced by the commands of lptc_ctrl.
module lptc_dp
	import lptc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic               cfg_wr_en,
	input  logic [QUOTA_W-1:0] cfg_wr_data,
	input  logic [KIND_W-1:0]  kind,
	input  logic [PID_W-1:0]   process_id,
	input  logic [PAGE_W-1:0]  process_page,
	input  logic [FRAME_W-1:0] global_frame,
	output logic               found,
	output logic [FRAME_W-1:0] frame_out
);

	localparam int CNT_W = ($clog2(ENTRIES + 1) > QUOTA_W) ? $clog2(ENTRIES + 1) : QUOTA_W;
	localparam logic [ENTRIES-1:0] ONE_V  = ENTRIES'(1);
	localparam logic [ENTRIES-1:0] LAST_V = ONE_V << (ENTRIES - 1);

	logic [ENTRIES-1:0] valid_q;
	logic [PID_W-1:0]   proc_q  [ENTRIES];
	logic [PAGE_W-1:0]  page_q  [ENTRIES];
	logic [FRAME_W-1:0] frm_q   [ENTRIES];
	logic [QUOTA_W-1:0] quota_q;

	kind_t              kind_s1;
	logic [PID_W-1:0]   pid_s1;
	logic [PAGE_W-1:0]  page_s1;
	logic [FRAME_W-1:0] frame_s1;
	logic [ENTRIES-1:0] look_s1;
	logic [ENTRIES-1:0] exact_s1;
	logic [ENTRIES-1:0] pidm_s1;

	logic               found_q;
	logic [FRAME_W-1:0] frame_q;

	logic [ENTRIES-1:0] look_c;
	logic [ENTRIES-1:0] exact_c;
	logic [ENTRIES-1:0] pidm_c;

	logic [ENTRIES-1:0] look_first;
	logic [ENTRIES-1:0] exact_first;
	logic [ENTRIES-1:0] cand;
	logic [QUOTA_W-1:0] quota_eff;
	logic [ENTRIES-1:0] pos;
	logic [ENTRIES-1:0] shift_mask;
	logic               do_shift;
	logic               new_valid;
	logic               res_found;
	logic [FRAME_W-1:0] res_frame;
	logic [FRAME_W-1:0] look_frame;

	// match against the incoming transaction
	always_comb begin
		for (int k = 0; k < ENTRIES; k++) begin
			pidm_c[k]  = valid_q[k] && (proc_q[k] == process_id);
			look_c[k]  = pidm_c[k] && (page_q[k] == process_page);
			exact_c[k] = look_c[k] && (frm_q[k] == global_frame);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_s1  <= kind_t'(kind);
			pid_s1   <= process_id;
			page_s1  <= process_page;
			frame_s1 <= global_frame;
			look_s1  <= look_c;
			exact_s1 <= exact_c;
			pidm_s1  <= pidm_c;
		end
	end

	assign look_first  = look_s1 & (~look_s1 + ONE_V);
	assign exact_first = exact_s1 & (~exact_s1 + ONE_V);
	assign quota_eff   = (quota_q == '0) ? QUOTA_MIN : quota_q;

	// slot at which the process's entry count reaches the quota
	always_comb begin
		logic [ENTRIES-1:0] prefix;
		logic [CNT_W-1:0]   cnt;
		prefix = '0;
		cnt    = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			prefix  = ENTRIES'({ENTRIES{1'b1}} >> (ENTRIES - 1 - k));
			cnt     = CNT_W'($countones(pidm_s1 & prefix));
			cand[k] = pidm_s1[k] && (cnt == CNT_W'(quota_eff));
		end
	end

	always_comb begin
		look_frame = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			look_frame = look_frame | (look_first[k] ? frm_q[k] : '0);
		end
	end

	always_comb begin
		do_shift  = 1'b0;
		new_valid = 1'b0;
		pos       = exact_first;
		res_found = 1'b0;
		res_frame = '0;
		unique case (kind_s1)
			KIND_LOOKUP: begin
				res_found = |look_s1;
				res_frame = look_frame;
			end
			KIND_INSERT: begin
				do_shift  = 1'b1;
				new_valid = 1'b1;
				res_found = |exact_s1;
				priority if (|exact_s1) begin
					pos = exact_first;
				end else if (|cand) begin
					pos = cand;
				end else begin
					pos = LAST_V;
				end
			end
			KIND_REMOVE: begin
				do_shift  = |exact_s1;
				res_found = |exact_s1;
			end
			default: begin
				do_shift = 1'b0;
			end
		endcase
	end

	assign shift_mask = (pos - ONE_V) | pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.apply && do_shift) begin
			valid_q[0] <= new_valid;
			for (int k = 1; k < ENTRIES; k++) begin
				if (shift_mask[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && do_shift) begin
			proc_q[0] <= new_valid ? pid_s1 : '0;
			page_q[0] <= new_valid ? page_s1 : '0;
			frm_q[0]  <= new_valid ? frame_s1 : '0;
			for (int k = 1; k < ENTRIES; k++) begin
				if (shift_mask[k]) begin
					proc_q[k] <= proc_q[k-1];
					page_q[k] <= page_q[k-1];
					frm_q[k]  <= frm_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quota_q <= QUOTA_RST;
		end else if (cfg_wr_en) begin
			quota_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			found_q <= res_found;
			frame_q <= res_frame;
		end
	end

	assign found     = found_q;
	assign frame_out = frame_q;

	a_quota_slot_unique: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> $onehot0(cand))
		else $error("more than one slot reaches the quota");

	a_insert_fills_front: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply && kind_s1 == KIND_INSERT |=> valid_q[0])
		else $error("insert left the front slot empty");

	a_remove_empties_front: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply && kind_s1 == KIND_REMOVE && (|exact_s1) |=> !valid_q[0])
		else $error("remove did not free the front slot");

	a_lookup_keeps_stack: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply && kind_s1 == KIND_LOOKUP |=> $stable(valid_q))
		else $error("lookup changed the slot stack");

endmodule

FILE: src/lru_page_translation_cache_unit.sv
// Top level of the LRU page translation cache with per-process quota.
// Depends on lptc_pkg, lptc_ctrl and lptc_dp.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------------
//  input    | in_valid / in_stall      | kind, process_id, process_page, global_frame
//  output   | out_valid / out_stall    | found, frame_out
//  config   | cfg_wr_en                | cfg_wr_data (per_process_quota)
//
// For each transaction, the accept registers the match vectors of all slots; the apply step
// then shifts the slot stack and loads the result register.
// A new transaction is accepted while the previous result still waits at the output.
// A stalled output holds the apply step, and with it the input.
// Reset empties every slot and sets the quota to four; no clearing pass is needed.
module lru_page_translation_cache_unit
	import lptc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [KIND_W-1:0]  kind,
	input  logic [PID_W-1:0]   process_id,
	input  logic [PAGE_W-1:0]  process_page,
	input  logic [FRAME_W-1:0] global_frame,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [FRAME_W-1:0] frame_out,
	input  logic               cfg_wr_en,
	input  logic [QUOTA_W-1:0] cfg_wr_data
);

	cmd_t cmd;

	lptc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	lptc_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.kind         (kind),
		.process_id   (process_id),
		.process_page (process_page),
		.global_frame (global_frame),
		.found        (found),
		.frame_out    (frame_out)
	);

endmodule

FILE: verif/tb.sv
// Testbench for lru_page_translation_cache_unit: a directed table, then random traffic.
// Results are checked against typed directed rows, else against a cycle-free model of the
// LRU stack with per-process quota. Depends on lptc_pkg and the RTL in src.
module tb;
	import lptc_pkg::*;

	localparam int SLOTS = ENTRIES_DEF;
	localparam int DIRECTED_ROWS = 22;
	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 155;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic               found;
		logic [FRAME_W-1:0] frame;
	} translation_t;

	typedef struct packed {
		logic [KIND_W-1:0]  op;
		logic [PID_W-1:0]   pid;
		logic [PAGE_W-1:0]  page;
		logic [FRAME_W-1:0] frame;
		logic               typed;
		logic               exp_found;
		logic [FRAME_W-1:0] exp_frame;
	} request_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [KIND_W-1:0]  kind;
	logic [PID_W-1:0]   process_id;
	logic [PAGE_W-1:0]  process_page;
	logic [FRAME_W-1:0] global_frame;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               found;
	logic [FRAME_W-1:0] frame_out;
	logic               cfg_wr_en;
	logic [QUOTA_W-1:0] cfg_wr_data;

	logic               cache_valid [SLOTS];
	logic [PID_W-1:0]   cache_pid   [SLOTS];
	logic [PAGE_W-1:0]  cache_page  [SLOTS];
	logic [FRAME_W-1:0] cache_frame [SLOTS];
	logic [QUOTA_W-1:0] quota;

	translation_t pending_translations [$];
	request_t     directed_requests [DIRECTED_ROWS];
	request_t     live_req;
	int           mismatches = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;

	lru_page_translation_cache_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.process_id  (process_id),
		.process_page(process_page),
		.global_frame(global_frame),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.frame_out   (frame_out),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic void cache_push(input int pos, input logic v, input logic [PID_W-1:0] pid,
			input logic [PAGE_W-1:0] page, input logic [FRAME_W-1:0] frame);
		for (int s = pos; s > 0; s--) begin
			cache_valid[s] = cache_valid[s-1];
			cache_pid[s]   = cache_pid[s-1];
			cache_page[s]  = cache_page[s-1];
			cache_frame[s] = cache_frame[s-1];
		end
		cache_valid[0] = v;
		cache_pid[0]   = v ? pid : '0;
		cache_page[0]  = v ? page : '0;
		cache_frame[0] = v ? frame : '0;
	endfunction

	function automatic int cache_find(input logic [PID_W-1:0] pid, input logic [PAGE_W-1:0] page,
			input logic [FRAME_W-1:0] frame);
		int hit;
		hit = -1;
		for (int s = SLOTS - 1; s >= 0; s--)
			if (cache_valid[s] && cache_pid[s] == pid && cache_page[s] == page &&
					cache_frame[s] == frame)
				hit = s;
		return hit;
	endfunction

	function automatic translation_t cache_apply(input logic [KIND_W-1:0] op,
			input logic [PID_W-1:0] pid, input logic [PAGE_W-1:0] page,
			input logic [FRAME_W-1:0] frame);
		translation_t r;
		int hit;
		int victim;
		int owned;
		int limit;
		logic taken;
		r = '0;
		hit = cache_find(pid, page, frame);
		case (op)
			KIND_LOOKUP: begin
				for (int s = SLOTS - 1; s >= 0; s--)
					if (cache_valid[s] && cache_pid[s] == pid && cache_page[s] == page) begin
						r.found = 1'b1;
						r.frame = cache_frame[s];
					end
			end
			KIND_INSERT: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					cache_push(hit, 1'b1, pid, page, frame);
				end else begin
					limit = (quota == '0) ? 1 : int'(quota);
					owned = 0;
					victim = SLOTS - 1;
					taken = 1'b0;
					for (int s = 0; s < SLOTS; s++)
						if (!taken) begin
							if (cache_valid[s] && cache_pid[s] == pid)
								owned++;
							if (owned == limit) begin
								victim = s;
								taken = 1'b1;
							end
						end
					cache_push(victim, 1'b1, pid, page, frame);
				end
			end
			KIND_REMOVE: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					cache_push(hit, 1'b0, '0, '0, '0);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(negedge clk) begin
		out_stall = ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin : watch
		translation_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_translations.size() == 0) begin
					report_mismatch("unrequested result, frame_out", 32'(frame_out), 32'(0));
				end else begin
					want = pending_translations.pop_front();
					if (found !== want.found)
						report_mismatch("found", 32'(found), 32'(want.found));
					if (frame_out !== want.frame)
						report_mismatch("frame_out", 32'(frame_out), 32'(want.frame));
				end
			end
			if (in_valid && !in_stall) begin
				want = cache_apply(kind, process_id, process_page, global_frame);
				if (live_req.typed) begin
					want.found = live_req.exp_found;
					want.frame = live_req.exp_frame;
				end
				pending_translations.push_back(want);
			end
			if (cfg_wr_en)
				quota = cfg_wr_data;
		end
	end

	task automatic send_item(input request_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		kind = r.op;
		process_id = r.pid;
		process_page = r.page;
		global_frame = r.frame;
		live_req = r;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_and_set_quota(input logic [QUOTA_W-1:0] q);
		in_valid = 1'b0;
		while (pending_translations.size() != 0)
			@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = q;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	initial begin
		logic [QUOTA_W-1:0] quota_plan [PHASES];
		logic [PID_W-1:0]   pid_pool [4];
		logic [PAGE_W-1:0]  page_pool [8];
		logic [FRAME_W-1:0] frame_pool [4];
		request_t r;
		int roll;
		int slot;

		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_LOOKUP;
		process_id = '0;
		process_page = '0;
		global_frame = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		live_req = '0;
		quota = QUOTA_RST;
		for (int s = 0; s < SLOTS; s++) begin
			cache_valid[s] = 1'b0;
			cache_pid[s] = '0;
			cache_page[s] = '0;
			cache_frame[s] = '0;
		end
		quota_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd5, 5'd3, 5'd8, 5'd4};

		directed_requests[0]  = '{KIND_LOOKUP, 8'h00, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000};
		directed_requests[1]  = '{KIND_REMOVE, 8'h00, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000};
		directed_requests[2]  = '{KIND_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'h0000};
		directed_requests[3]  = '{KIND_INSERT, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'h0000};
		directed_requests[4]  = '{KIND_LOOKUP, 8'hFF, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'hFFFF};
		directed_requests[5]  = '{KIND_INSERT, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h0000};
		directed_requests[6]  = '{KIND_INSERT, 8'hFF, 16'hFFFF, 16'h1234, 1'b1, 1'b0, 16'h0000};
		directed_requests[7]  = '{KIND_LOOKUP, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'h1234};
		directed_requests[8]  = '{KIND_LOOKUP, 8'hFE, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 16'h0000};
		directed_requests[9]  = '{KIND_REMOVE, 8'hFF, 16'hFFFF, 16'h0BAD, 1'b1, 1'b0, 16'h0000};
		directed_requests[10] = '{KIND_INSERT, 8'h01, 16'h0001, 16'h0010, 1'b0, 1'b0, 16'h0000};
		directed_requests[11] = '{KIND_INSERT, 8'h01, 16'h0002, 16'h0020, 1'b0, 1'b0, 16'h0000};
		directed_requests[12] = '{KIND_INSERT, 8'h01, 16'h0003, 16'h0030, 1'b0, 1'b0, 16'h0000};
		directed_requests[13] = '{KIND_INSERT, 8'h01, 16'h0004, 16'h0040, 1'b0, 1'b0, 16'h0000};
		directed_requests[14] = '{KIND_INSERT, 8'h01, 16'h0005, 16'h0050, 1'b0, 1'b0, 16'h0000};
		directed_requests[15] = '{KIND_LOOKUP, 8'h01, 16'h0001, 16'h0000, 1'b0, 1'b0, 16'h0000};
		directed_requests[16] = '{KIND_LOOKUP, 8'h01, 16'h0002, 16'h0000, 1'b0, 1'b0, 16'h0000};
		directed_requests[17] = '{KIND_INSERT, 8'h01, 16'h0002, 16'h0020, 1'b0, 1'b0, 16'h0000};
		directed_requests[18] = '{KIND_REMOVE, 8'h01, 16'h0003, 16'h0030, 1'b0, 1'b0, 16'h0000};
		directed_requests[19] = '{KIND_LOOKUP, 8'h01, 16'h0003, 16'h0000, 1'b0, 1'b0, 16'h0000};
		directed_requests[20] = '{KIND_REMOVE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 16'h0000};
		directed_requests[21] = '{KIND_LOOKUP, 8'h00, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000};

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		send_idle_pct = 17;
		recv_stall_pct = 66;
		@(negedge clk);

		for (int n = 0; n < DIRECTED_ROWS; n++)
			send_item(directed_requests[n]);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 3) begin
				send_idle_pct = 66;
				recv_stall_pct = 17;
			end
			if (ph == 6) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			drain_and_set_quota(quota_plan[ph]);
			for (int i = 0; i < 4; i++) begin
				pid_pool[i] = PID_W'($urandom);
				frame_pool[i] = FRAME_W'($urandom);
			end
			for (int i = 0; i < 8; i++)
				page_pool[i] = PAGE_W'($urandom);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				r = '0;
				roll = $urandom_range(0, 99);
				if (roll < 10) begin
					r.op = KIND_W'($urandom_range(0, 3));
					r.pid = PID_W'($urandom);
					r.page = PAGE_W'($urandom);
					r.frame = FRAME_W'($urandom);
				end else begin
					roll = $urandom_range(0, 99);
					r.op = (roll < 30) ? KIND_LOOKUP : (roll < 75) ? KIND_INSERT : KIND_REMOVE;
					slot = $urandom_range(0, SLOTS - 1);
					if ($urandom_range(0, 1) == 1 && cache_valid[slot]) begin
						r.pid = cache_pid[slot];
						r.page = cache_page[slot];
						r.frame = cache_frame[slot];
					end else begin
						r.pid = pid_pool[$urandom_range(0, 3)];
						r.page = page_pool[$urandom_range(0, 7)];
						r.frame = frame_pool[$urandom_range(0, 3)];
					end
				end
				send_item(r);
			end
		end

		in_valid = 1'b0;
		while (pending_translations.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
